// ===== sv/marp_pkg.sv =====
// ----------------------------------------------------------------------------
// marp_pkg: shared types and constants of the MIDI arpeggiator
// Note store geometry, event codes, player states and sequencer states.
// ----------------------------------------------------------------------------
package marp_pkg;

    localparam int NOTE_DEPTH = 16;
    localparam int IDX_W      = $clog2(NOTE_DEPTH);
    localparam int CNT_W      = $clog2(NOTE_DEPTH + 1);
    localparam int TICK_W     = 9;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 9;
    localparam int TDATA_W    = 24;

    localparam logic [TICK_W-1:0] PPS_RESET   = 9'd24;
    localparam logic [TICK_W-1:0] PHASE_RESET = 9'd12;

    // input kinds
    localparam logic [2:0] KIND_NOTE_ON  = 3'd0;
    localparam logic [2:0] KIND_NOTE_OFF = 3'd1;
    localparam logic [2:0] KIND_PRESSURE = 3'd2;
    localparam logic [2:0] KIND_TICK     = 3'd3;
    localparam logic [2:0] KIND_START    = 3'd4;
    localparam logic [2:0] KIND_STOP     = 3'd5;

    // output event kinds
    localparam logic [1:0] EV_NOTE_ON  = 2'd0;
    localparam logic [1:0] EV_NOTE_OFF = 2'd1;
    localparam logic [1:0] EV_PRESSURE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_ENABLE = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_DIR    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_HOLD   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_EXT    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_PPS    = 3'd4;

    // direction modes
    localparam logic [1:0] DIR_UP       = 2'd0;
    localparam logic [1:0] DIR_DOWN     = 2'd1;
    localparam logic [1:0] DIR_UPDOWN   = 2'd2;
    localparam logic [1:0] DIR_ASSIGNED = 2'd3;

    typedef struct packed {
        logic [3:0] ch;
        logic [6:0] vel;
        logic [6:0] note;
    } note_entry_t;

    localparam int ENTRY_W = $bits(note_entry_t);

    typedef enum logic [1:0] {
        PL_DISABLED,
        PL_IDLE,
        PL_NOTEON,
        PL_NOTEOFF
    } player_t;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_BYPASS,
        S_RM_RD, S_RM_CHK, S_SH_RD, S_SH_WR, S_RM_DONE,
        S_HF_RD, S_HF_CHK, S_OFF_SEL,
        S_RP, S_SA_RD, S_SA_EM, S_PSW,
        S_SN, S_SN_LAT, S_SC_RD, S_SC_CHK, S_SC_END, S_SN_EMIT,
        S_RPEND, S_FINISH,
        S_PR_ARD, S_PR_ALAT, S_PR_HRD, S_PR_HCHK
    } seq_state_t;

    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        note_entry_t ent;
    } emit_t;

    typedef struct packed {
        logic emit_ready;
        logic pend_valid;
        logic flush_ready;
    } out_status_t;

endpackage

// ===== sv/midi_arpeggiator_top.sv =====
// ----------------------------------------------------------------------------
// midi_arpeggiator_top: MIDI arpeggiator, up / down / up-down / assigned
// Note and held-key stores live in two RAMs; a sequencer scans them.
//
//   Port group  Dir  Payload
//   s_*         in   tuser: kind; tdata: note, velocity, channel
//   m_*         out  tuser: event_kind; tdata: note, velocity, channel; tlast
//   cfg_*       in   write enable, register index, 9-bit data
//
// One item at a time: a player step walks the stored notes once for each
// RAM scan (stop-all, search). Leaving hold runs a nested scan of both
// RAMs, during which no transfer is taken.
// Reset is synchronous; the RAMs are not cleared. A stalled master side
// holds the sequencer at its next result.
// ----------------------------------------------------------------------------
module midi_arpeggiator_top
    import marp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_W-1:0]    s_tdata,   // note, velocity, channel
    input  logic [2:0]            s_tuser,   // kind
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_W-1:0]    m_tdata,   // out_note, out_velocity, out_channel
    output logic [1:0]            m_tuser,   // event_kind
    output logic                  m_tlast,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam logic [CNT_W-1:0] FULL = CNT_W'(NOTE_DEPTH);
    localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);

    seq_state_t st_reg, st_next;

    logic             en_reg, hold_reg, ext_reg, prune_pend_reg;
    logic [1:0]       dir_reg;
    logic [TICK_W-1:0] pps_reg, tick_reg, phase_reg;

    logic [2:0]       in_kind_reg;
    note_entry_t      in_ent_reg;

    logic [CNT_W-1:0] arp_count_reg, held_count_reg;
    player_t          player_reg, rp_prev_reg;
    note_entry_t      cur_reg, prev_reg, ent_reg, cand_reg, edge_reg;
    logic             going_down_reg, hold_reset_reg, prev_en_reg;
    logic             started_reg, prev_started_reg;
    logic             np_reg, found_reg, up_reg;
    logic [IDX_W-1:0] step_reg;
    logic [CNT_W-1:0] i_reg, j_reg, k_reg;

    // RAM ports
    logic             a_we, h_we;
    logic [IDX_W-1:0] a_waddr, a_raddr, h_waddr, h_raddr;
    note_entry_t      a_wdata, a_rdata;
    logic [6:0]       h_wdata, h_rdata;

    emit_t            emit;
    logic             flush;
    out_status_t      ost;

    // combinational helpers
    logic             is_off, find_only, emit_rdy;
    logic [TICK_W-1:0] tick_inc;
    logic [CNT_W-1:0] add_base, i_inc;
    logic [CNT_W-1:0] step_inc;
    logic [1:0]       mode_eff;
    logic             cond, better, edge_upd;
    player_t          rp_ps;
    logic             rp_stop;

    assign is_off    = (in_kind_reg == KIND_NOTE_OFF) ||
                       ((in_kind_reg == KIND_NOTE_ON) && (in_ent_reg.vel == 7'd0));
    assign find_only = en_reg && hold_reg;
    assign emit_rdy  = ost.emit_ready;
    assign tick_inc  = tick_reg + TICK_W'(1);
    assign add_base  = (hold_reg && hold_reset_reg) ? '0 : arp_count_reg;
    assign i_inc     = i_reg + ONE;
    assign step_inc  = (CNT_W'(step_reg) + ONE >= arp_count_reg) ? '0
                                                               : CNT_W'(step_reg) + ONE;
    assign mode_eff  = (dir_reg == DIR_UPDOWN) ? (going_down_reg ? DIR_DOWN : DIR_UP)
                                               : dir_reg;
    assign cond      = up_reg ? (a_rdata.note > cur_reg.note) : (a_rdata.note < cur_reg.note);
    assign better    = up_reg ? (a_rdata.note < cand_reg.note) : (a_rdata.note > cand_reg.note);
    assign edge_upd  = up_reg ? (a_rdata.note < edge_reg.note) : (a_rdata.note > edge_reg.note);

    // player transition on a run
    always_comb begin
        rp_ps   = player_reg;
        rp_stop = 1'b0;
        if (prev_en_reg != en_reg) begin
            if (en_reg && !ext_reg) begin
                rp_stop = 1'b1;
                rp_ps   = PL_IDLE;
            end else begin
                rp_ps = PL_DISABLED;
            end
        end else if (en_reg && (prev_started_reg != started_reg)) begin
            if (started_reg) begin
                rp_stop = 1'b1;
                rp_ps   = PL_IDLE;
            end else begin
                rp_ps = PL_DISABLED;
            end
        end
    end

    // next state
    always_comb begin
        st_next = st_reg;
        case (st_reg)
            S_IDLE: begin
                if (prune_pend_reg) st_next = S_PR_ARD;
                else if (s_tvalid) st_next = S_DECODE;
            end
            S_DECODE: begin
                case (in_kind_reg)
                    KIND_PRESSURE: if (emit_rdy) st_next = S_FINISH;
                    KIND_TICK: st_next = (tick_inc >= phase_reg) ? S_RP : S_FINISH;
                    KIND_START, KIND_STOP: st_next = S_RP;
                    KIND_NOTE_ON, KIND_NOTE_OFF: begin
                        if (!en_reg) st_next = S_BYPASS;
                        else if (is_off) st_next = S_HF_RD;
                        else st_next = (player_reg == PL_IDLE) ? S_RP : S_FINISH;
                    end
                    default: st_next = S_FINISH;
                endcase
            end
            S_BYPASS: if (emit_rdy) st_next = is_off ? S_RM_RD : S_FINISH;
            S_RM_RD: st_next = (i_reg >= arp_count_reg) ? S_RM_DONE : S_RM_CHK;
            S_RM_CHK: begin
                if (a_rdata.note == in_ent_reg.note) st_next = find_only ? S_RM_DONE : S_SH_RD;
                else st_next = S_RM_RD;
            end
            S_SH_RD: st_next = (i_inc >= arp_count_reg) ? S_RM_DONE : S_SH_WR;
            S_SH_WR: st_next = S_SH_RD;
            S_RM_DONE: begin
                if (!en_reg) st_next = S_FINISH;
                else if (found_reg || emit_rdy) begin
                    if (!hold_reg && (arp_count_reg == '0)) st_next = S_RP;
                    else st_next = S_FINISH;
                end
            end
            S_HF_RD: st_next = (i_reg >= held_count_reg) ? S_OFF_SEL : S_HF_CHK;
            S_HF_CHK: st_next = S_HF_RD;
            S_OFF_SEL: st_next = S_RM_RD;
            S_RP: st_next = rp_stop ? S_SA_RD : S_PSW;
            S_SA_RD: st_next = (i_reg >= arp_count_reg) ? S_PSW : S_SA_EM;
            S_SA_EM: if (emit_rdy) st_next = S_SA_RD;
            S_PSW: begin
                case (player_reg)
                    PL_DISABLED: begin
                        if (rp_prev_reg != PL_NOTEON || emit_rdy) st_next = S_RPEND;
                    end
                    PL_IDLE, PL_NOTEOFF: st_next = (arp_count_reg != '0) ? S_SN : S_RPEND;
                    PL_NOTEON: if (emit_rdy) st_next = S_RPEND;
                    default: st_next = S_RPEND;
                endcase
            end
            S_SN: begin
                if (arp_count_reg == ONE || mode_eff == DIR_ASSIGNED) st_next = S_SN_LAT;
                else st_next = S_SC_RD;
            end
            S_SN_LAT: st_next = S_SN_EMIT;
            S_SC_RD: st_next = (i_reg >= arp_count_reg) ? S_SC_END : S_SC_CHK;
            S_SC_CHK: st_next = S_SC_RD;
            S_SC_END: st_next = S_SN_EMIT;
            S_SN_EMIT: if (emit_rdy) st_next = S_RPEND;
            S_RPEND: st_next = S_FINISH;
            S_FINISH: if (!ost.pend_valid || ost.flush_ready) st_next = S_IDLE;
            S_PR_ARD: st_next = (i_reg >= arp_count_reg) ? S_IDLE : S_PR_ALAT;
            S_PR_ALAT: st_next = S_PR_HRD;
            S_PR_HRD: st_next = (j_reg >= held_count_reg) ? S_PR_ARD : S_PR_HCHK;
            S_PR_HCHK: st_next = (h_rdata == ent_reg.note) ? S_PR_ARD : S_PR_HRD;
            default: st_next = S_IDLE;
        endcase
    end

    // outputs: RAM controls, results, handshake
    always_comb begin
        s_tready = (st_reg == S_IDLE) && !prune_pend_reg;
        a_we     = 1'b0;
        a_waddr  = add_base[IDX_W-1:0];
        a_wdata  = in_ent_reg;
        a_raddr  = i_reg[IDX_W-1:0];
        h_we     = 1'b0;
        h_waddr  = held_count_reg[IDX_W-1:0];
        h_wdata  = in_ent_reg.note;
        h_raddr  = i_reg[IDX_W-1:0];
        emit     = '0;
        flush    = 1'b0;
        case (st_reg)
            S_DECODE: begin
                if (in_kind_reg == KIND_PRESSURE) begin
                    emit.valid = 1'b1;
                    emit.kind  = EV_PRESSURE;
                    emit.ent   = in_ent_reg;
                end else if ((in_kind_reg == KIND_NOTE_ON || in_kind_reg == KIND_NOTE_OFF)
                             && en_reg && !is_off) begin
                    h_we = held_count_reg < FULL;
                    a_we = add_base < FULL;
                end
            end
            S_BYPASS: begin
                emit.valid = 1'b1;
                emit.kind  = in_kind_reg[1:0];
                emit.ent   = in_ent_reg;
                a_waddr    = arp_count_reg[IDX_W-1:0];
                a_we       = emit_rdy && !is_off && (arp_count_reg < FULL);
            end
            S_SH_RD: a_raddr = i_inc[IDX_W-1:0];
            S_SH_WR: begin
                a_we    = 1'b1;
                a_waddr = i_reg[IDX_W-1:0];
                a_wdata = a_rdata;
            end
            S_RM_DONE: begin
                emit.valid = en_reg && !found_reg;
                emit.kind  = in_kind_reg[1:0];
                emit.ent   = in_ent_reg;
            end
            S_HF_CHK: begin
                h_we    = h_rdata != in_ent_reg.note;
                h_waddr = k_reg[IDX_W-1:0];
                h_wdata = h_rdata;
            end
            S_SA_EM: begin
                emit.valid    = 1'b1;
                emit.kind     = EV_NOTE_OFF;
                emit.ent      = a_rdata;
                emit.ent.vel  = 7'd0;
            end
            S_PSW: begin
                emit.kind    = EV_NOTE_OFF;
                emit.ent     = cur_reg;
                emit.ent.vel = 7'd0;
                emit.valid   = (player_reg == PL_NOTEON) ||
                               (player_reg == PL_DISABLED && rp_prev_reg == PL_NOTEON);
            end
            S_SN: begin
                a_raddr = (arp_count_reg == ONE) ? '0 : step_inc[IDX_W-1:0];
            end
            S_SN_EMIT: begin
                emit.valid = 1'b1;
                emit.kind  = EV_NOTE_ON;
                emit.ent   = cur_reg;
            end
            S_FINISH: flush = 1'b1;
            S_PR_HRD: h_raddr = j_reg[IDX_W-1:0];
            S_PR_HCHK: begin
                h_raddr = j_reg[IDX_W-1:0];
                a_we    = h_rdata == ent_reg.note;
                a_waddr = k_reg[IDX_W-1:0];
                a_wdata = ent_reg;
            end
            default: ;
        endcase
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg           <= S_IDLE;
            en_reg           <= 1'b0;
            dir_reg          <= DIR_UP;
            hold_reg         <= 1'b0;
            ext_reg          <= 1'b0;
            pps_reg          <= PPS_RESET;
            phase_reg        <= PHASE_RESET;
            tick_reg         <= '0;
            prune_pend_reg   <= 1'b0;
            arp_count_reg    <= '0;
            held_count_reg   <= '0;
            player_reg       <= PL_DISABLED;
            cur_reg          <= '0;
            prev_reg         <= '0;
            going_down_reg   <= 1'b0;
            step_reg         <= '0;
            hold_reset_reg   <= 1'b1;
            prev_en_reg      <= 1'b0;
            started_reg      <= 1'b0;
            prev_started_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            case (st_reg)
                S_IDLE: begin
                    i_reg <= '0;
                    k_reg <= '0;
                    if (s_tvalid && s_tready) begin
                        in_kind_reg <= s_tuser;
                        in_ent_reg  <= s_tdata[ENTRY_W-1:0];
                    end
                end
                S_DECODE: begin
                    np_reg <= 1'b1;
                    case (in_kind_reg)
                        KIND_TICK: tick_reg <= tick_inc;
                        KIND_START, KIND_STOP: begin
                            started_reg      <= in_kind_reg == KIND_START;
                            prev_started_reg <= in_kind_reg != KIND_START;
                        end
                        KIND_NOTE_ON, KIND_NOTE_OFF: begin
                            found_reg <= 1'b0;
                            if (en_reg && !is_off) begin
                                if (held_count_reg < FULL) held_count_reg <= held_count_reg + ONE;
                                arp_count_reg  <= (add_base < FULL) ? add_base + ONE : add_base;
                                hold_reset_reg <= 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
                S_BYPASS: begin
                    if (emit_rdy && !is_off && arp_count_reg < FULL) begin
                        arp_count_reg <= arp_count_reg + ONE;
                    end
                end
                S_RM_CHK: begin
                    if (a_rdata.note == in_ent_reg.note) found_reg <= 1'b1;
                    else i_reg <= i_inc;
                end
                S_SH_RD: begin
                    if (i_inc >= arp_count_reg) arp_count_reg <= arp_count_reg - ONE;
                end
                S_SH_WR: i_reg <= i_inc;
                S_RM_DONE: np_reg <= 1'b0;
                S_HF_RD: begin
                    if (i_reg >= held_count_reg) begin
                        held_count_reg <= k_reg;
                        hold_reset_reg <= k_reg == '0;
                    end
                end
                S_HF_CHK: begin
                    if (h_rdata != in_ent_reg.note) k_reg <= k_reg + ONE;
                    i_reg <= i_inc;
                end
                S_OFF_SEL: i_reg <= '0;
                S_RP: begin
                    i_reg       <= '0;
                    rp_prev_reg <= player_reg;
                    player_reg  <= rp_ps;
                    if (prev_en_reg != en_reg) begin
                        prev_en_reg <= en_reg;
                        if (en_reg && !ext_reg) begin
                            started_reg      <= 1'b1;
                            prev_started_reg <= 1'b1;
                        end else begin
                            prev_started_reg <= 1'b0;
                        end
                    end else if (en_reg && (prev_started_reg != started_reg)) begin
                        prev_started_reg <= started_reg;
                    end
                end
                S_SA_EM: if (emit_rdy) i_reg <= i_inc;
                S_PSW: begin
                    case (player_reg)
                        PL_DISABLED: begin
                            if (rp_prev_reg != PL_DISABLED &&
                                (rp_prev_reg != PL_NOTEON || emit_rdy)) begin
                                arp_count_reg  <= '0;
                                held_count_reg <= '0;
                            end
                        end
                        PL_IDLE: begin
                            if (arp_count_reg != '0) begin
                                going_down_reg <= 1'b0;
                                player_reg     <= PL_NOTEON;
                            end
                        end
                        PL_NOTEON: begin
                            if (emit_rdy) begin
                                player_reg <= (arp_count_reg != '0) ? PL_NOTEOFF : PL_IDLE;
                            end
                        end
                        PL_NOTEOFF: begin
                            player_reg <= (arp_count_reg != '0) ? PL_NOTEON : PL_IDLE;
                        end
                        default: ;
                    endcase
                end
                S_SN: begin
                    i_reg     <= '0;
                    found_reg <= 1'b0;
                    up_reg    <= mode_eff == DIR_UP;
                    if (arp_count_reg != ONE && mode_eff == DIR_ASSIGNED) begin
                        step_reg <= step_inc[IDX_W-1:0];
                    end
                end
                S_SN_LAT: cur_reg <= a_rdata;
                S_SC_CHK: begin
                    if (i_reg == '0 || edge_upd) edge_reg <= a_rdata;
                    if (cond && (!found_reg || better)) begin
                        cand_reg  <= a_rdata;
                        found_reg <= 1'b1;
                    end
                    i_reg <= i_inc;
                end
                S_SC_END: begin
                    if (found_reg) begin
                        prev_reg <= cur_reg;
                        cur_reg  <= cand_reg;
                    end else if (dir_reg != DIR_UPDOWN) begin
                        cur_reg <= edge_reg;
                    end else begin
                        // turnaround: replay the previous note
                        going_down_reg <= up_reg;
                        cur_reg        <= prev_reg;
                        prev_reg       <= cur_reg;
                    end
                end
                S_RPEND: begin
                    if (np_reg) begin
                        phase_reg <= pps_reg - phase_reg;
                        tick_reg  <= '0;
                    end
                end
                S_PR_ARD: begin
                    if (i_reg >= arp_count_reg) begin
                        arp_count_reg  <= k_reg;
                        prune_pend_reg <= 1'b0;
                    end
                end
                S_PR_ALAT: begin
                    ent_reg <= a_rdata;
                    j_reg   <= '0;
                end
                S_PR_HRD: if (j_reg >= held_count_reg) i_reg <= i_inc;
                S_PR_HCHK: begin
                    if (h_rdata == ent_reg.note) begin
                        k_reg <= k_reg + ONE;
                        i_reg <= i_inc;
                    end else begin
                        j_reg <= j_reg + ONE;
                    end
                end
                default: ;
            endcase

            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_ENABLE: en_reg <= cfg_wdata[0];
                    CFG_DIR:    dir_reg <= cfg_wdata[1:0];
                    CFG_HOLD: begin
                        // leaving hold: prune unheld notes before the next transfer
                        if (hold_reg && !cfg_wdata[0]) prune_pend_reg <= 1'b1;
                        hold_reg <= cfg_wdata[0];
                    end
                    CFG_EXT:    ext_reg <= cfg_wdata[0];
                    CFG_PPS: begin
                        pps_reg   <= cfg_wdata;
                        phase_reg <= cfg_wdata >> 1;
                    end
                    default: ;
                endcase
            end
        end
    end

    marp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NOTE_DEPTH)
    ) u_arp_ram (
        .aclk  (aclk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    marp_ram #(
        .WIDTH (7),
        .DEPTH (NOTE_DEPTH)
    ) u_held_ram (
        .aclk  (aclk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    marp_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .emit_i   (emit),
        .flush_i  (flush),
        .status_o (ost),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== sv/marp_ram.sv =====
// ----------------------------------------------------------------------------
// marp_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module marp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/marp_out.sv =====
// ----------------------------------------------------------------------------
// marp_out: result staging and output register
// Holds one result back until the next one, or the end of the item, shows
// whether it is the last; then moves it to the master-side register.
// ----------------------------------------------------------------------------
module marp_out
    import marp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  emit_t               emit_i,
    input  logic                flush_i,
    output out_status_t         status_o,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [TDATA_W-1:0]  m_tdata,   // out_note, out_velocity, out_channel
    output logic [1:0]          m_tuser,   // event_kind
    output logic                m_tlast
);

    localparam int PAD_W = TDATA_W - ENTRY_W;

    logic        pend_valid_reg;
    logic [1:0]  pend_kind_reg;
    note_entry_t pend_ent_reg;
    logic        out_valid_reg;
    logic [1:0]  out_kind_reg;
    note_entry_t out_ent_reg;
    logic        out_last_reg;
    logic        out_free;

    assign out_free             = !out_valid_reg || m_tready;
    assign status_o.emit_ready  = !pend_valid_reg || out_free;
    assign status_o.pend_valid  = pend_valid_reg;
    assign status_o.flush_ready = out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (emit_i.valid && status_o.emit_ready) begin
                if (pend_valid_reg) begin
                    out_valid_reg <= 1'b1;
                    out_kind_reg  <= pend_kind_reg;
                    out_ent_reg   <= pend_ent_reg;
                    out_last_reg  <= 1'b0;
                end
                pend_valid_reg <= 1'b1;
                pend_kind_reg  <= emit_i.kind;
                pend_ent_reg   <= emit_i.ent;
            end else if (flush_i && pend_valid_reg && out_free) begin
                // end of item: the held result is the last one
                out_valid_reg  <= 1'b1;
                out_kind_reg   <= pend_kind_reg;
                out_ent_reg    <= pend_ent_reg;
                out_last_reg   <= 1'b1;
                pend_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_ent_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== dv/tb_midi_arpeggiator_top.sv =====
// ----------------------------------------------------------------------------
// tb_midi_arpeggiator_top: self-checking bench for the MIDI arpeggiator
// A directed table opens the run. Random MIDI traffic follows, under a series
// of register settings. Every accepted event runs through a behavioural copy
// of the arpeggiator; each master-side transfer is compared in order with
// what that copy predicts, or with the expected event of a typed table row.
// ----------------------------------------------------------------------------
module tb_midi_arpeggiator_top;
    import marp_pkg::*;

    localparam int MAX_EVENTS  = NOTE_DEPTH + 2;
    localparam int SETTLE_CYC  = 700;
    localparam int STALL_LIMIT = 20000;
    localparam int PHASE_ITEMS = 39;

    typedef struct packed {
        logic [1:0] kind;
        logic [6:0] note;
        logic [6:0] vel;
        logic [3:0] ch;
        logic       last;
    } midi_ev_t;

    typedef struct {
        logic [2:0] kind;
        logic [6:0] note;
        logic [6:0] vel;
        logic [3:0] ch;
        bit         typed;
        int         n_typed;
        midi_ev_t   ev;
    } stim_row_t;

    typedef struct {
        bit         en;
        logic [1:0] dir;
        bit         hold;
        bit         ext;
        logic [8:0] pps;
        bit         calm;
    } arp_setting_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [TDATA_W-1:0]    s_tdata   = '0;
    logic [2:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    midi_arpeggiator_top u_dut (.*);

    always #6 aclk = ~aclk;

    // predictor state
    bit          en_r, hold_r, ext_r;
    logic [1:0]  dir_r;
    logic [8:0]  pps_r;
    note_entry_t arp_st [NOTE_DEPTH];
    int          arp_n;
    logic [6:0]  held_st [NOTE_DEPTH];
    int          held_n;
    player_t     pl;
    note_entry_t cur_nt, prev_nt;
    bit          going_down;
    int          step_idx;
    logic [8:0]  ticks, phase_len;
    bit          hold_rst, prev_en, run_on, prev_run;

    midi_ev_t    step_out [$];
    midi_ev_t    expected_events [$];
    int          errors;
    int          quiet_cycles;
    bit          calm;

    task automatic report(input string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        errors++;
    endtask

    function automatic void emit_ev(input logic [1:0] k, input note_entry_t e);
        midi_ev_t r;
        if (step_out.size() >= MAX_EVENTS) return;
        r.kind = k; r.note = e.note; r.vel = e.vel; r.ch = e.ch; r.last = 1'b0;
        step_out.insert(step_out.size(), r);
    endfunction

    function automatic bit drop_arp(input logic [6:0] n);
        for (int i = 0; i < arp_n; i++) begin
            if (arp_st[i].note == n) begin
                for (int j = i; j < arp_n - 1; j++) arp_st[j] = arp_st[j+1];
                arp_n--;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic note_entry_t pick_next();
        logic [1:0]  mode;
        bit          found, up;
        note_entry_t cand, far_nt, r;
        mode = dir_r;
        found = 1'b0;
        cand = arp_st[0];
        far_nt = arp_st[0];
        if (arp_n == 1) return arp_st[0];
        if (mode == DIR_UPDOWN) mode = going_down ? DIR_DOWN : DIR_UP;
        if (mode == DIR_ASSIGNED) begin
            step_idx++;
            if (step_idx >= arp_n) step_idx = 0;
            return arp_st[step_idx];
        end
        up = (mode == DIR_UP);
        for (int i = 0; i < arp_n; i++) begin
            if (up ? (arp_st[i].note > cur_nt.note) : (arp_st[i].note < cur_nt.note)) begin
                if (!found || (up ? (arp_st[i].note < cand.note)
                                  : (arp_st[i].note > cand.note))) begin
                    cand = arp_st[i];
                    found = 1'b1;
                end
            end
            if (up ? (arp_st[i].note < far_nt.note) : (arp_st[i].note > far_nt.note))
                far_nt = arp_st[i];
        end
        if (found) begin
            prev_nt = cur_nt;
            return cand;
        end
        if (dir_r != DIR_UPDOWN) return far_nt;
        // turnaround: replay the previous note
        going_down = up;
        r = prev_nt;
        prev_nt = cur_nt;
        return r;
    endfunction

    function automatic void send_next();
        cur_nt = pick_next();
        emit_ev(EV_NOTE_ON, cur_nt);
    endfunction

    function automatic void stop_all();
        note_entry_t e;
        for (int i = 0; i < arp_n; i++) begin
            e = arp_st[i];
            e.vel = '0;
            emit_ev(EV_NOTE_OFF, e);
        end
    endfunction

    function automatic void step_player();
        player_t     was;
        note_entry_t e;
        was = pl;
        if (prev_en != en_r) begin
            if (en_r && !ext_r) begin
                stop_all();
                pl = PL_IDLE;
                run_on = 1'b1;
                prev_run = 1'b1;
            end else begin
                pl = PL_DISABLED;
                prev_run = 1'b0;
            end
            prev_en = en_r;
        end else if (en_r && prev_run != run_on) begin
            if (run_on) begin
                stop_all();
                pl = PL_IDLE;
            end else begin
                pl = PL_DISABLED;
            end
            prev_run = run_on;
        end
        e = cur_nt;
        e.vel = '0;
        case (pl)
            PL_DISABLED: begin
                if (was != PL_DISABLED) begin
                    if (was == PL_NOTEON) emit_ev(EV_NOTE_OFF, e);
                    arp_n = 0;
                    held_n = 0;
                end
            end
            PL_IDLE: begin
                if (arp_n > 0) begin
                    going_down = 1'b0;
                    send_next();
                    pl = PL_NOTEON;
                end
            end
            PL_NOTEON: begin
                emit_ev(EV_NOTE_OFF, e);
                pl = (arp_n > 0) ? PL_NOTEOFF : PL_IDLE;
            end
            default: begin
                if (arp_n > 0) begin
                    send_next();
                    pl = PL_NOTEON;
                end else begin
                    pl = PL_IDLE;
                end
            end
        endcase
    endfunction

    function automatic void next_phase();
        phase_len = pps_r - phase_len;
        ticks = '0;
    endfunction

    function automatic void arp_reset();
        en_r = 0; dir_r = DIR_UP; hold_r = 0; ext_r = 0; pps_r = PPS_RESET;
        arp_n = 0; held_n = 0; pl = PL_DISABLED;
        cur_nt = '0; prev_nt = '0; going_down = 0; step_idx = 0;
        ticks = '0; phase_len = PHASE_RESET;
        hold_rst = 1; prev_en = 0; run_on = 0; prev_run = 0;
    endfunction

    function automatic void arp_write_reg(input logic [CFG_ADDR_W-1:0] a,
                                          input logic [8:0] v);
        int  k;
        bit  keep;
        case (a)
            CFG_ENABLE: en_r = v[0];
            CFG_DIR:    dir_r = v[1:0];
            CFG_HOLD: begin
                // leaving hold: keep only entries whose key is still down
                if (hold_r && !v[0]) begin
                    k = 0;
                    for (int i = 0; i < arp_n; i++) begin
                        keep = 0;
                        for (int j = 0; j < held_n; j++)
                            if (held_st[j] == arp_st[i].note) keep = 1;
                        if (keep) arp_st[k++] = arp_st[i];
                    end
                    arp_n = k;
                end
                hold_r = v[0];
            end
            CFG_EXT: ext_r = v[0];
            CFG_PPS: begin
                pps_r = v;
                phase_len = v >> 1;
            end
            default: ;
        endcase
    endfunction

    function automatic void arp_event(input logic [2:0] kind, input note_entry_t e);
        bit is_off;
        int k;
        step_out.delete();
        is_off = (kind == KIND_NOTE_OFF) || (kind == KIND_NOTE_ON && e.vel == 0);
        if (kind == KIND_PRESSURE) begin
            emit_ev(EV_PRESSURE, e);
        end else if (kind == KIND_TICK) begin
            ticks = ticks + 9'd1;
            if (ticks >= phase_len) begin
                step_player();
                next_phase();
            end
        end else if (kind == KIND_START || kind == KIND_STOP) begin
            run_on = (kind == KIND_START);
            prev_run = !run_on;
            step_player();
            next_phase();
        end else if (kind == KIND_NOTE_ON || kind == KIND_NOTE_OFF) begin
            if (!en_r) begin
                emit_ev(kind[1:0], e);
                if (!is_off) begin
                    if (arp_n < NOTE_DEPTH) arp_st[arp_n++] = e;
                end else begin
                    void'(drop_arp(e.note));
                end
            end else if (is_off) begin
                k = 0;
                for (int i = 0; i < held_n; i++)
                    if (held_st[i] != e.note) held_st[k++] = held_st[i];
                held_n = k;
                hold_rst = (held_n == 0);
                if (!hold_r) begin
                    if (!drop_arp(e.note)) emit_ev(kind[1:0], e);
                    if (arp_n == 0) step_player();
                end else begin
                    k = 0;
                    for (int i = 0; i < arp_n; i++) if (arp_st[i].note == e.note) k = 1;
                    if (k == 0) emit_ev(kind[1:0], e);
                end
            end else begin
                if (held_n < NOTE_DEPTH) held_st[held_n++] = e.note;
                if (hold_r && hold_rst) arp_n = 0;
                if (arp_n < NOTE_DEPTH) arp_st[arp_n++] = e;
                if (pl == PL_IDLE) begin
                    step_player();
                    next_phase();
                end
                hold_rst = (held_n == 0);
            end
        end
        if (step_out.size() > 0) step_out[step_out.size()-1].last = 1'b1;
    endfunction

    // drive one event and wait for its transfer
    task automatic send_event(input stim_row_t r);
        note_entry_t e;
        @(negedge aclk);
        while (!calm && $urandom_range(99) < 30) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.kind;
        s_tdata  <= {6'd0, r.ch, r.vel, r.note};
        do @(posedge aclk); while (!s_tready);
        e.note = r.note; e.vel = r.vel; e.ch = r.ch;
        arp_event(r.kind, e);
        if (r.typed) begin
            if (r.n_typed > 0) expected_events.insert(expected_events.size(), r.ev);
        end else begin
            expected_events = {expected_events, step_out};
        end
    endtask

    task automatic drain();
        // drop the request so the last transfer is not taken again
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_events.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] a, input logic [8:0] v);
        @(negedge aclk);
        s_tvalid  <= 1'b0;
        cfg_wr_en <= 1'b1;
        cfg_addr  <= a;
        cfg_wdata <= v;
        @(posedge aclk);
        arp_write_reg(a, v);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic stim_row_t row(input logic [2:0] k, input logic [6:0] n,
                                      input logic [6:0] v, input logic [3:0] c,
                                      input bit typed, input int nt,
                                      input logic [1:0] ek);
        stim_row_t r;
        r.kind = k; r.note = n; r.vel = v; r.ch = c;
        r.typed = typed; r.n_typed = nt;
        r.ev = '{kind: ek, note: n, vel: v, ch: c, last: 1'b1};
        return r;
    endfunction

    function automatic stim_row_t random_row(input logic [6:0] base);
        int        p;
        stim_row_t r;
        p = $urandom_range(99);
        r = row(KIND_TICK, 7'($urandom_range(127)), 7'($urandom_range(127)),
                4'($urandom_range(15)), 0, 0, EV_NOTE_ON);
        // stay within a small pool most of the time so offs find their notes
        if ($urandom_range(9) != 0) r.note = base + 7'($urandom_range(7));
        if (p < 42)      r.kind = KIND_TICK;
        else if (p < 64) begin
            r.kind = KIND_NOTE_ON;
            if ($urandom_range(9) == 0) r.vel = '0;
        end
        else if (p < 83) r.kind = KIND_NOTE_OFF;
        else if (p < 88) r.kind = KIND_PRESSURE;
        else if (p < 93) r.kind = KIND_START;
        else if (p < 97) r.kind = KIND_STOP;
        else             r.kind = 3'($urandom_range(7, 6));
        return r;
    endfunction

    // receiver: random back-pressure unless a calm stretch is running
    always @(negedge aclk) m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 30);

    always @(posedge aclk) begin
        midi_ev_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_events.size() == 0) begin
                report($sformatf("unexpected event kind %0d note %0d", m_tuser,
                                 m_tdata[6:0]));
            end else begin
                want = expected_events.pop_front();
                if (m_tuser !== want.kind)
                    report($sformatf("kind %0d, want %0d", m_tuser, want.kind));
                if (m_tdata[6:0] !== want.note)
                    report($sformatf("note %0d, want %0d", m_tdata[6:0], want.note));
                if (m_tdata[13:7] !== want.vel)
                    report($sformatf("velocity %0d, want %0d", m_tdata[13:7], want.vel));
                if (m_tdata[17:14] !== want.ch)
                    report($sformatf("channel %0d, want %0d", m_tdata[17:14], want.ch));
                if (m_tlast !== want.last)
                    report($sformatf("tlast %0b, want %0b", m_tlast, want.last));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        stim_row_t    table_rows [$];
        arp_setting_t plan [$];
        logic [6:0]   base;

        errors = 0;
        quiet_cycles = 0;
        calm = 0;
        arp_reset();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // bypass after reset: notes go straight through
        table_rows = {table_rows, row(KIND_NOTE_ON,  7'd127, 7'd127, 4'd15, 1, 1, EV_NOTE_ON)};
        table_rows = {table_rows, row(KIND_NOTE_ON,  7'd0,   7'd1,   4'd0,  1, 1, EV_NOTE_ON)};
        table_rows = {table_rows, row(KIND_PRESSURE, 7'd64,  7'd127, 4'd15, 1, 1, EV_PRESSURE)};
        table_rows = {table_rows, row(KIND_PRESSURE, 7'd0,   7'd0,   4'd0,  1, 1, EV_PRESSURE)};
        table_rows = {table_rows, row(3'd6,          7'd127, 7'd127, 4'd15, 1, 0, EV_NOTE_ON)};
        table_rows = {table_rows, row(3'd7,          7'd1,   7'd1,   4'd1,  1, 0, EV_NOTE_ON)};
        table_rows = {table_rows, row(KIND_NOTE_OFF, 7'd0,   7'd0,   4'd0,  1, 1, EV_NOTE_OFF)};
        table_rows = {table_rows, row(KIND_NOTE_ON,  7'd127, 7'd0,   4'd15, 1, 1, EV_NOTE_ON)};
        table_rows = {table_rows, row(KIND_NOTE_OFF, 7'd55,  7'd64,  4'd9,  1, 1, EV_NOTE_OFF)};
        table_rows = {table_rows, row(KIND_TICK,     7'd0,   7'd0,   4'd0,  1, 0, EV_NOTE_ON)};
        table_rows = {table_rows, row(KIND_START,    7'd0,   7'd0,   4'd0,  0, 0, EV_NOTE_ON)};
        table_rows = {table_rows, row(KIND_STOP,     7'd0,   7'd0,   4'd0,  0, 0, EV_NOTE_ON)};
        // overfill the note store
        for (int i = 0; i < 18; i++)
            table_rows = {table_rows, row(KIND_NOTE_ON, 7'(40 + 3 * i), 7'(100 + i), 4'(i),
                                          0, 0, EV_NOTE_ON)};
        foreach (table_rows[i]) send_event(table_rows[i]);

        plan = {plan, arp_setting_t'{1, DIR_UP,       0, 0, 9'd4,   0}};
        plan = {plan, arp_setting_t'{1, DIR_DOWN,     0, 0, 9'd3,   0}};
        plan = {plan, arp_setting_t'{1, DIR_UPDOWN,   0, 0, 9'd6,   1}};
        plan = {plan, arp_setting_t'{1, DIR_ASSIGNED, 1, 0, 9'd5,   0}};
        plan = {plan, arp_setting_t'{1, DIR_UPDOWN,   0, 1, 9'd2,   0}};
        plan = {plan, arp_setting_t'{0, DIR_UP,       1, 0, 9'd24,  0}};
        plan = {plan, arp_setting_t'{1, DIR_UP,       0, 0, 9'd1,   0}};
        plan = {plan, arp_setting_t'{1, DIR_ASSIGNED, 0, 0, 9'd0,   0}};
        plan = {plan, arp_setting_t'{1, DIR_DOWN,     1, 1, 9'd384, 0}};
        plan = {plan, arp_setting_t'{1, DIR_UPDOWN,   0, 0, 9'd255, 0}};

        foreach (plan[p]) begin
            drain();
            calm = 0;
            write_reg(CFG_HOLD,   {8'd0, plan[p].hold});
            write_reg(CFG_DIR,    {7'd0, plan[p].dir});
            write_reg(CFG_EXT,    {8'd0, plan[p].ext});
            write_reg(CFG_PPS,    plan[p].pps);
            write_reg(CFG_ENABLE, {8'd0, plan[p].en});
            calm = plan[p].calm;
            base = 7'($urandom_range(120));
            for (int i = 0; i < PHASE_ITEMS; i++) send_event(random_row(base));
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        calm = 0;
        drain();
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
